[sv/ycrgb_pkg.sv]
// ----------------------------------------------------------------------------
// ycrgb_pkg
// Shared types and fixed-point constants of the 4:2:0 YCbCr to RGB888 converter.
// ----------------------------------------------------------------------------
package ycrgb_pkg;

	// bt.601 coefficients, 16-bit fraction, sized to the product width
	localparam int PROD_W = 27;
	localparam logic signed [PROD_W-1:0] C_CR_R = 27'sd104597;
	localparam logic signed [PROD_W-1:0] C_CB_G = 27'sd25674;
	localparam logic signed [PROD_W-1:0] C_CR_G = 27'sd53278;
	localparam logic signed [PROD_W-1:0] C_CB_B = 27'sd132201;
	localparam logic signed [PROD_W-1:0] C_Y    = 27'sd76309;
	localparam logic signed [8:0]        CHROMA_OFS = 9'sd128;
	localparam logic signed [8:0]        LUMA_OFS   = 9'sd16;
	localparam int FRAC_BITS = 16;

	// configuration register indexes
	localparam logic [1:0] REG_BLOCK_COLS = 2'd0;
	localparam logic [1:0] REG_BLOCK_ROWS = 2'd1;
	localparam logic [1:0] REG_ROW_STRIDE = 2'd2;

	localparam logic [10:0] RST_BLOCK_COLS = 11'd160;
	localparam logic [10:0] RST_BLOCK_ROWS = 11'd120;
	localparam logic [12:0] RST_ROW_STRIDE = 13'd960;
	localparam int CNT_LIMIT = 1024;

	typedef logic signed [9:0] chroma_term_t;

	// red in the low byte so a pixel drops straight into tdata
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// pipeline enables shared by all stage-holding modules
	typedef struct packed {
		logic acc;   // input transaction, loads stage 1
		logic adv2;  // stage 1 moves into stage 2
	} ctl_t;

endpackage

[sv/ycbcr420_to_rgb_flip_core.sv]
// ----------------------------------------------------------------------------
// ycbcr420_to_rgb_flip_core
// 4:2:0 YCbCr blocks to packed RGB888 pixel pairs with a vertical flip.
// ----------------------------------------------------------------------------
// channel   dir  transfer on             payload
// s_*       in   s_tvalid & s_tready     one 2x2 luma block with Cb and Cr
// m_*       out  m_tvalid & m_tready     one pixel pair and its byte offset
// wr_*      in   wr_en                   geometry register write
//
// four pixel lanes and a shared chroma unit run two stages, then a result
// register sends the upper pair and then the lower pair of each block.
// the stages can take new blocks while the result register still sends; in
// steady state the two output transactions per block set the input rate.
// reset clears the pipeline valids and block counters and loads the default geometry.
// a stalled output backs up the two stages before input ready drops.
// ----------------------------------------------------------------------------
module ycbcr420_to_rgb_flip_core
	import ycrgb_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [12:0] wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
	// chroma_blue, chroma_red
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// red_left, green_left, blue_left, red_right, green_right, blue_right,
	// byte_offset
	output logic [71:0] m_tdata,
	output logic        m_tlast,
	// frame_done
	output logic        m_tuser
);

	ctl_t         ctl;
	logic         v1_q;
	logic         v2_q;
	logic         vo_q;
	logic         phase_q;
	logic         free1;
	logic         free2;
	logic         ld_out;
	chroma_term_t term_r;
	chroma_term_t term_g;
	chroma_term_t term_b;
	pixel_t       pix [4];
	pixel_t       pix_q [4];
	logic [23:0]  off_up;
	logic [23:0]  off_lo;
	logic         frame_end;
	logic [23:0]  off_up_q;
	logic [23:0]  off_lo_q;
	logic         done_q;

	assign ld_out   = v2_q && (!vo_q || (m_tready && phase_q));
	assign free2    = !v2_q || ld_out;
	assign free1    = !v1_q || free2;
	assign s_tready = free1;
	assign ctl.acc  = s_tvalid && free1;
	assign ctl.adv2 = v1_q && free2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (free1) begin
				v1_q <= s_tvalid;
			end
			if (free2) begin
				v2_q <= v1_q;
			end
		end
	end

	ycrgb_chroma u_chroma (
		.clk         (clk),
		.ctl         (ctl),
		.chroma_blue (s_tdata[39:32]),
		.chroma_red  (s_tdata[47:40]),
		.term_r      (term_r),
		.term_g      (term_g),
		.term_b      (term_b)
	);

	for (genvar k = 0; k < 4; k++) begin : g_lane
		ycrgb_lane u_lane (
			.clk    (clk),
			.ctl    (ctl),
			.luma   (s_tdata[8*k +: 8]),
			.term_r (term_r),
			.term_g (term_g),
			.term_b (term_b),
			.pix    (pix[k])
		);
	end

	ycrgb_addr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.ctl       (ctl),
		.off_up    (off_up),
		.off_lo    (off_lo),
		.frame_end (frame_end)
	);

	// merge: hold both pairs of a block, upper first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q    <= 1'b0;
			phase_q <= 1'b0;
		end else if (ld_out) begin
			vo_q    <= 1'b1;
			phase_q <= 1'b0;
		end else if (vo_q && m_tready) begin
			if (phase_q) begin
				vo_q <= 1'b0;
			end
			phase_q <= !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			for (int k = 0; k < 4; k++) begin
				pix_q[k] <= pix[k];
			end
			off_up_q <= off_up;
			off_lo_q <= off_lo;
			done_q   <= frame_end;
		end
	end

	assign m_tvalid = vo_q;
	assign m_tlast  = phase_q;
	assign m_tuser  = phase_q && done_q;
	assign m_tdata  = phase_q ? {off_lo_q, pix_q[3], pix_q[2]}
	                          : {off_up_q, pix_q[1], pix_q[0]};

`ifndef ASSERT_OFF
	// an upper pair is always followed by its lower pair
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
		else $error("upper pair not followed by lower pair");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tuser |-> m_tlast)
		else $error("frame end flagged on upper pair");

	// input stalls only when every stage holds a block
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v1_q && v2_q && vo_q)
		else $error("input stalled with a free stage");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> m_tvalid && !m_tlast)
		else $error("loaded block does not start with upper pair");
`endif

endmodule

[sv/ycrgb_chroma.sv]
// ----------------------------------------------------------------------------
// ycrgb_chroma
// Shared chroma terms of one block: red, green and blue offsets from Cb and Cr.
// ----------------------------------------------------------------------------
module ycrgb_chroma
	import ycrgb_pkg::*;
(
	input  logic         clk,
	input  ctl_t         ctl,
	input  logic [7:0]   chroma_blue,
	input  logic [7:0]   chroma_red,
	output chroma_term_t term_r,
	output chroma_term_t term_g,
	output chroma_term_t term_b
);

	logic signed [8:0]        cb;
	logic signed [8:0]        cr;
	logic signed [PROD_W-1:0] pr_s1;
	logic signed [PROD_W-1:0] pg_s1;
	logic signed [PROD_W-1:0] pb_s1;
	logic signed [PROD_W-1:0] shr;
	logic signed [PROD_W-1:0] shg;
	logic signed [PROD_W-1:0] shb;

	assign cb = $signed({1'b0, chroma_blue}) - CHROMA_OFS;
	assign cr = $signed({1'b0, chroma_red}) - CHROMA_OFS;

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			pr_s1 <= PROD_W'(cr) * C_CR_R;
			pg_s1 <= PROD_W'(cb) * C_CB_G + PROD_W'(cr) * C_CR_G;
			pb_s1 <= PROD_W'(cb) * C_CB_B;
		end
	end

	// floor shifts; all results fit ten signed bits
	assign shr = pr_s1 >>> FRAC_BITS;
	assign shg = pg_s1 >>> FRAC_BITS;
	assign shb = pb_s1 >>> FRAC_BITS;
	assign term_r = shr[9:0];
	assign term_g = shg[9:0];
	assign term_b = shb[9:0];

endmodule

[sv/ycrgb_lane.sv]
// ----------------------------------------------------------------------------
// ycrgb_lane
// One pixel lane: scales a luma sample and adds the shared chroma terms.
// ----------------------------------------------------------------------------
module ycrgb_lane
	import ycrgb_pkg::*;
(
	input  logic         clk,
	input  ctl_t         ctl,
	input  logic [7:0]   luma,
	input  chroma_term_t term_r,
	input  chroma_term_t term_g,
	input  chroma_term_t term_b,
	output pixel_t       pix
);

	logic signed [8:0]        yd;
	logic signed [PROD_W-1:0] py_s1;
	logic signed [PROD_W-1:0] ysh;
	logic signed [9:0]        y;
	logic signed [10:0]       sr;
	logic signed [10:0]       sg;
	logic signed [10:0]       sb;
	pixel_t                   pix_s2;

	function automatic logic [7:0] clamp8(input logic signed [10:0] v);
		logic [7:0] res;
		if (v < 0) begin
			res = 8'd0;
		end else if (v > 11'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

	assign yd = $signed({1'b0, luma}) - LUMA_OFS;

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			py_s1 <= PROD_W'(yd) * C_Y;
		end
	end

	assign ysh = py_s1 >>> FRAC_BITS;
	assign y   = ysh[9:0];
	assign sr  = 11'(y) + 11'(term_r);
	assign sg  = 11'(y) - 11'(term_g);
	assign sb  = 11'(y) + 11'(term_b);

	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			pix_s2.red   <= clamp8(sr);
			pix_s2.green <= clamp8(sg);
			pix_s2.blue  <= clamp8(sb);
		end
	end

	assign pix = pix_s2;

endmodule

[sv/ycrgb_addr.sv]
// ----------------------------------------------------------------------------
// ycrgb_addr
// Geometry registers, block counters and flipped destination offsets.
// ----------------------------------------------------------------------------
module ycrgb_addr
	import ycrgb_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [12:0] wr_data,
	input  ctl_t        ctl,
	output logic [23:0] off_up,
	output logic [23:0] off_lo,
	output logic        frame_end
);

	localparam int COL_HALF = MAX_WIDTH / 2;
	localparam int ROW_HALF = MAX_HEIGHT / 2;
	localparam int COL_LIM_I = (COL_HALF > CNT_LIMIT) ? CNT_LIMIT : ((COL_HALF < 1) ? 1 : COL_HALF);
	localparam int ROW_LIM_I = (ROW_HALF > CNT_LIMIT) ? CNT_LIMIT : ((ROW_HALF < 1) ? 1 : ROW_HALF);
	localparam logic [10:0] COL_LIM = 11'(COL_LIM_I);
	localparam logic [10:0] ROW_LIM = 11'(ROW_LIM_I);

	logic [10:0] block_cols_q;
	logic [10:0] block_rows_q;
	logic [12:0] row_stride_q;
	logic [9:0]  col_cnt_q;
	logic [9:0]  row_cnt_q;

	logic [10:0] cols;
	logic [10:0] rows;
	logic [9:0]  col_max;
	logic [9:0]  row_max;
	logic [9:0]  c_eff;
	logic [9:0]  r_eff;
	logic        last_col;
	logic        last_row;

	logic [23:0] prod_s1;
	logic [9:0]  col_s1;
	logic        done_s1;
	logic [23:0] c6;
	logic [23:0] up_d;
	logic [23:0] up_s2;
	logic [23:0] lo_s2;
	logic        done_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_cols_q <= RST_BLOCK_COLS;
			block_rows_q <= RST_BLOCK_ROWS;
			row_stride_q <= RST_ROW_STRIDE;
		end else if (wr_en) begin
			case (wr_index)
				REG_BLOCK_COLS: block_cols_q <= wr_data[10:0];
				REG_BLOCK_ROWS: block_rows_q <= wr_data[10:0];
				REG_ROW_STRIDE: row_stride_q <= wr_data;
				default: ;
			endcase
		end
	end

	// geometry in use, saturated to the supported range
	always_comb begin
		if (block_cols_q == 11'd0) begin
			cols = 11'd1;
		end else if (block_cols_q > COL_LIM) begin
			cols = COL_LIM;
		end else begin
			cols = block_cols_q;
		end
		if (block_rows_q == 11'd0) begin
			rows = 11'd1;
		end else if (block_rows_q > ROW_LIM) begin
			rows = ROW_LIM;
		end else begin
			rows = block_rows_q;
		end
	end

	assign col_max  = 10'(cols - 11'd1);
	assign row_max  = 10'(rows - 11'd1);
	assign c_eff    = (col_cnt_q > col_max) ? col_max : col_cnt_q;
	assign r_eff    = (row_cnt_q > row_max) ? row_max : row_cnt_q;
	assign last_col = (c_eff == col_max);
	assign last_row = (r_eff == row_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (ctl.acc) begin
			if (last_col) begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row ? 10'd0 : r_eff + 10'd1;
			end else begin
				col_cnt_q <= c_eff + 10'd1;
				row_cnt_q <= r_eff;
			end
		end
	end

	// mirrored row times two pixel rows
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			prod_s1 <= 24'(row_max - r_eff) * 24'({row_stride_q, 1'b0});
			col_s1  <= c_eff;
			done_s1 <= last_col && last_row;
		end
	end

	assign c6   = 24'({col_s1, 2'b00}) + 24'({col_s1, 1'b0});
	assign up_d = prod_s1 + c6;

	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			up_s2   <= up_d;
			lo_s2   <= up_d + 24'(row_stride_q);
			done_s2 <= done_s1;
		end
	end

	assign off_up    = up_s2;
	assign off_lo    = lo_s2;
	assign frame_end = done_s2;

endmodule

[tb/sv/tb_ycbcr420_to_rgb_flip_core.sv]
// ----------------------------------------------------------------------------
// tb_ycbcr420_to_rgb_flip_core
// Self-checking bench for the 4:2:0 YCbCr to RGB888 flip converter. A short
// table of directed blocks and geometry writes runs first, then random phases
// over several frame geometries. Every block is run through a local model of
// the color math and the flipped addressing, and each output transaction is
// compared field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ycbcr420_to_rgb_flip_core;
	import ycrgb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 6;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_BLOCKS   = 140;
	localparam int GEO_LIMIT      = 1024;
	localparam int DIRECTED_STEPS = 23;

	// bt.601 factors with a 16-bit fraction
	localparam int K_CR_R = 104597;
	localparam int K_CB_G = 25674;
	localparam int K_CR_G = 53278;
	localparam int K_CB_B = 132201;
	localparam int K_Y    = 76309;

	typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HALF, SINK_PATTERN} sink_mode_e;

	typedef struct packed {
		pixel_t      left;
		pixel_t      right;
		logic [23:0] offset;
		logic        last_of_pair;
		logic        frame_done;
	} pair_t;

	typedef struct {
		bit          is_geometry;
		logic [47:0] blk;
		int          level;  // typed grey level of all channels, -1 if modeled
		int          cols;
		int          rows;
		int          stride;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_BLOCK_COLS;
	logic [12:0] wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	// local copy of the geometry registers and block counters
	logic [10:0] geo_cols = 11'd160;
	logic [10:0] geo_rows = 11'd120;
	logic [12:0] geo_stride = 13'd960;
	int          blk_col = 0;
	int          blk_row = 0;

	pair_t pair_expect[$];
	int    grey_level[$];
	int    fail_count = 0;
	int    quiet_cycles = 0;
	int    burst_left = 0;
	bit    sender_quiet = 0;
	bit    hold_request = 0;

	ycbcr420_to_rgb_flip_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [47:0] pack_block(int tl, int tr, int bl, int br, int cb, int cr);
		return {cr[7:0], cb[7:0], br[7:0], bl[7:0], tr[7:0], tl[7:0]};
	endfunction

	function automatic logic [7:0] sat8(int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	function automatic int geo_in_use(logic [10:0] v);
		if (v < 1) return 1;
		if (v > GEO_LIMIT) return GEO_LIMIT;
		return int'(v);
	endfunction

	task automatic check_field(string name, logic [23:0] want_v, logic [23:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	task automatic push_block(logic [47:0] blk, int level);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (sender_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		grey_level.push_back(level);
		s_tvalid <= 1'b1;
		s_tdata  <= blk;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// registers change only once all pairs are out and the pipe has drained
	task automatic write_geometry(int cols, int rows, int stride);
		s_tvalid <= 1'b0;
		// let the model queue the last accepted block before the queue is checked
		@(posedge clk);
		while (pair_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= REG_BLOCK_COLS;
		wr_data  <= {2'($urandom_range(0, 3)), 11'(cols)};
		@(posedge clk);
		wr_index <= REG_BLOCK_ROWS;
		wr_data  <= {2'($urandom_range(0, 3)), 11'(rows)};
		@(posedge clk);
		wr_index <= REG_ROW_STRIDE;
		wr_data  <= 13'(stride);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// model: register writes and accepted blocks, two pairs per block
	always @(posedge clk) begin : block_model
		int         cols, rows, c, r, cb, cr, t_r, t_g, t_b, y, level;
		logic       last_col, last_row;
		longint     base;
		pixel_t     px;
		pair_t      p;
		if (arst_n) begin
			if (wr_en) begin
				case (wr_index)
					REG_BLOCK_COLS: geo_cols = wr_data[10:0];
					REG_BLOCK_ROWS: geo_rows = wr_data[10:0];
					REG_ROW_STRIDE: geo_stride = wr_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				level = grey_level.pop_front();
				cols = geo_in_use(geo_cols);
				rows = geo_in_use(geo_rows);
				// counters left beyond a shrunk geometry stick to the last column or row
				c = (blk_col > cols - 1) ? cols - 1 : blk_col;
				r = (blk_row > rows - 1) ? rows - 1 : blk_row;
				last_col = (c == cols - 1);
				last_row = (r == rows - 1);
				cb = int'(s_tdata[39:32]) - 128;
				cr = int'(s_tdata[47:40]) - 128;
				t_r = (cr * K_CR_R) >>> 16;
				t_g = (cb * K_CB_G + cr * K_CR_G) >>> 16;
				t_b = (cb * K_CB_B) >>> 16;
				base = longint'(rows - 1 - r) * 2 * longint'(geo_stride) + longint'(c) * 6;
				for (int k = 0; k < 2; k++) begin
					for (int j = 0; j < 2; j++) begin
						y = ((int'(s_tdata[16*k + 8*j +: 8]) - 16) * K_Y) >>> 16;
						px.red   = sat8(y + t_r);
						px.green = sat8(y - t_g);
						px.blue  = sat8(y + t_b);
						if (level >= 0) px = {level[7:0], level[7:0], level[7:0]};
						if (j == 0) p.left = px;
						else p.right = px;
					end
					p.offset = 24'(base + longint'(k) * longint'(geo_stride));
					p.last_of_pair = (k == 1);
					p.frame_done = (k == 1) && last_col && last_row;
					pair_expect.push_back(p);
				end
				if (last_col) begin
					blk_col = 0;
					blk_row = last_row ? 0 : r + 1;
				end else begin
					blk_col = c + 1;
					blk_row = r;
				end
			end
		end
	end

	always @(posedge clk) begin : pair_check
		pair_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pair_expect.size() == 0) begin
				$error("unexpected pair transaction, m_tdata=%h", m_tdata);
				fail_count++;
			end else begin
				want = pair_expect.pop_front();
				check_field("red_left", want.left.red, m_tdata[7:0]);
				check_field("green_left", want.left.green, m_tdata[15:8]);
				check_field("blue_left", want.left.blue, m_tdata[23:16]);
				check_field("red_right", want.right.red, m_tdata[31:24]);
				check_field("green_right", want.right.green, m_tdata[39:32]);
				check_field("blue_right", want.right.blue, m_tdata[47:40]);
				check_field("byte_offset", want.offset, m_tdata[71:48]);
				check_field("last_of_pair", want.last_of_pair, m_tlast);
				check_field("frame_done", want.frame_done, m_tuser);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_ycbcr420_to_rgb_flip_core: FAIL");
			$finish;
		end
	end

	initial begin : sink_pacing
		sink_mode_e mode;
		int         mode_left;
		logic [6:0] pat;
		mode = SINK_OPEN;
		mode_left = 0;
		pat = 7'b1011001;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// long hold-off so the pipe backs up into the input
				hold_request = 0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = sink_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				pat = {pat[5:0], pat[6]};
				case (mode)
					SINK_OPEN:  m_tready <= 1'b1;
					SINK_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
					SINK_HALF:  m_tready <= 1'($urandom_range(0, 1));
					default:    m_tready <= pat[0];
				endcase
			end
		end
	end

	initial begin : stimulus
		step_t       directed [DIRECTED_STEPS];
		logic [47:0] blk;
		int          cols, rows, stride;

		// first rows run on the reset geometry in the top block row, so their offsets point at the flipped bottom row
		directed = '{
			'{0, pack_block(16, 16, 16, 16, 128, 128), 0, 0, 0, 0},
			'{0, pack_block(255, 255, 255, 255, 128, 128), 255, 0, 0, 0},
			'{0, pack_block(0, 0, 0, 0, 128, 128), 0, 0, 0, 0},
			'{0, pack_block(235, 235, 235, 235, 128, 128), 254, 0, 0, 0},
			'{0, pack_block(128, 128, 128, 128, 0, 0), -1, 0, 0, 0},
			'{0, pack_block(128, 128, 128, 128, 255, 255), -1, 0, 0, 0},
			'{0, pack_block(128, 128, 128, 128, 0, 255), -1, 0, 0, 0},
			'{0, pack_block(128, 128, 128, 128, 255, 0), -1, 0, 0, 0},
			'{0, pack_block(0, 255, 16, 235, 0, 0), -1, 0, 0, 0},
			'{0, pack_block(255, 0, 235, 16, 255, 255), -1, 0, 0, 0},
			'{0, pack_block(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55), -1, 0, 0, 0},
			'{0, pack_block(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA), -1, 0, 0, 0},
			'{0, pack_block(81, 145, 41, 210, 90, 240), -1, 0, 0, 0},
			// one-block frame, counters left mid-frame get clamped
			'{1, '0, -1, 1, 1, 6},
			'{0, pack_block(200, 30, 60, 90, 10, 250), -1, 0, 0, 0},
			'{0, pack_block(3, 250, 128, 77, 180, 20), -1, 0, 0, 0},
			// zero geometry saturates to one block
			'{1, '0, -1, 0, 0, 0},
			'{0, pack_block(16, 235, 235, 16, 128, 128), -1, 0, 0, 0},
			'{1, '0, -1, 2, 2, 12},
			'{0, pack_block(10, 20, 30, 40, 50, 60), -1, 0, 0, 0},
			'{0, pack_block(70, 80, 90, 100, 110, 120), -1, 0, 0, 0},
			'{0, pack_block(130, 140, 150, 160, 170, 180), -1, 0, 0, 0},
			'{0, pack_block(190, 200, 210, 220, 230, 240), -1, 0, 0, 0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_geometry)
				write_geometry(directed[i].cols, directed[i].rows, directed[i].stride);
			else
				push_block(directed[i].blk, directed[i].level);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				1: begin cols = 2047; rows = 2047; stride = 8191; end
				2: begin cols = 0; rows = 0; stride = 0; end
				3: begin cols = 1024; rows = 1024; stride = 6144; end
				default: begin
					cols = $urandom_range(1, 6);
					rows = $urandom_range(1, 5);
					case ($urandom_range(0, 3))
						0: stride = 6;
						1: stride = 8191;
						default: stride = $urandom_range(6, 6144);
					endcase
				end
			endcase
			write_geometry(cols, rows, stride);
			sender_quiet = (ph % 4 == 2);
			if (ph == 5) hold_request = 1;
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				for (int f = 0; f < 6; f++) begin
					case ($urandom_range(0, 7))
						0: blk[8*f +: 8] = 8'd0;
						1: blk[8*f +: 8] = 8'd255;
						2: blk[8*f +: 8] = 8'd16;
						3: blk[8*f +: 8] = 8'd235;
						default: blk[8*f +: 8] = 8'($urandom_range(0, 255));
					endcase
				end
				push_block(blk, -1);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pair_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_ycbcr420_to_rgb_flip_core: PASS");
		else
			$display("tb_ycbcr420_to_rgb_flip_core: FAIL");
		$finish;
	end

endmodule
